/* rtl/kcr_pkg.sv */
// Shared types, constants and pair-index helpers for the Kuramoto coupling block.
package kcr_pkg;

    // Oscillators per item and binary-angle width of one phase
    localparam int NUM_OSC     = 6;
    localparam int ANGLE_BITS  = 16;
    localparam int NUM_PAIRS   = NUM_OSC * (NUM_OSC - 1) / 2;

    // Wrapped difference width and sine datapath widths
    localparam int DIFF_W      = 16;
    localparam int AZ_W        = 29;           // |d*(32768-|d|)| <= 2^28
    localparam int SQ_W        = 2 * AZ_W;
    localparam int T31_W       = AZ_W + 5;
    localparam int NUM_W       = 62;           // 40 * 2^56 < 2^62
    localparam int H_W         = NUM_W - 47;   // numerator over 2^47
    localparam int Q_W         = 13;           // quotient by 5, at most 4096
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 18;
    localparam logic [RECIP_W-1:0] RECIP5 = 16'hCCCD;
    localparam int SINE_W      = Q_W + 1;

    // Rate and drift formats
    localparam int RATE_W      = 16;
    localparam int DRIFT_W     = 15;
    localparam int SUM_W       = SINE_W + $clog2(NUM_OSC) + 2;
    localparam logic signed [DRIFT_W-1:0] DRIFT_RESET = 15'sd4096;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (RATE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 << (RATE_W - 1));

    // Pipeline depth of one lane
    localparam int LANE_STAGES = 6;

    typedef logic [ANGLE_BITS-1:0]    phase_t;
    typedef logic signed [SINE_W-1:0] sine_t;
    typedef logic signed [RATE_W-1:0] rate_t;
    typedef logic signed [DRIFT_W-1:0] drift_t;

    // Stage load strobes shared by every lane
    typedef struct packed {
        logic [LANE_STAGES-1:0] en;
    } lane_ctrl_t;

    // First member i of pair p in the order (0,1),(0,2)..(1,2)..
    function automatic int pair_first(input int p);
        int idx;
        int res;
        idx = 0;
        res = 0;
        for (int i = 0; i < NUM_OSC; i++)
        begin
            for (int j = i + 1; j < NUM_OSC; j++)
            begin
                if (idx == p)
                    res = i;
                idx++;
            end
        end
        return res;
    endfunction

    // Second member j of pair p
    function automatic int pair_second(input int p);
        int idx;
        int res;
        idx = 0;
        res = 0;
        for (int i = 0; i < NUM_OSC; i++)
        begin
            for (int j = i + 1; j < NUM_OSC; j++)
            begin
                if (idx == p)
                    res = j;
                idx++;
            end
        end
        return res;
    endfunction

endpackage

/* rtl/kcr_lane.sv */
// One pair lane: wrapped phase difference and parabolic sine, six stages.
module kcr_lane
    import kcr_pkg::*;
(
    input  logic       clk,
    input  lane_ctrl_t ctrl,
    input  phase_t     phase_i,
    input  phase_t     phase_j,
    output sine_t      sine
);

    logic [ANGLE_BITS-1:0] raw;
    logic [DIFF_W-1:0]     diff;

    logic [DIFF_W-1:0]     d_reg;
    logic [DIFF_W-1:0]     ad;
    logic [DIFF_W-1:0]     comp;
    logic [2*DIFF_W-1:0]   zprod;
    logic [AZ_W-1:0]       az1_reg;
    logic                  neg1_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [AZ_W-1:0]       az2_reg;
    logic                  neg2_reg;
    logic [T31_W-1:0]      t31;
    logic [NUM_W-1:0]      num;
    logic [H_W-1:0]        h_reg;
    logic                  low_reg;
    logic                  neg3_reg;
    logic [H_W+RECIP_W-1:0] qprod;
    logic [Q_W-1:0]        q_reg;
    logic [H_W-1:0]        h5_reg;
    logic                  low5_reg;
    logic                  neg5_reg;
    logic [H_W-1:0]        q5;
    logic                  inexact;
    logic [SINE_W-1:0]     mag;
    sine_t                 s_reg;

    // Modular difference, brought to 16 bits
    assign raw = phase_i - phase_j;
    generate
        if (ANGLE_BITS >= DIFF_W)
        begin : g_trunc
            assign diff = raw[ANGLE_BITS-1 -: DIFF_W];
        end
        else
        begin : g_pad
            assign diff = {raw, {(DIFF_W - ANGLE_BITS){1'b0}}};
        end
    endgenerate

    // Stage 1: difference register
    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
            d_reg <= diff;
    end

    // Stage 2: |z| = |d| * (32768 - |d|)
    assign ad    = d_reg[DIFF_W-1] ? DIFF_W'(-d_reg) : d_reg;
    assign comp  = DIFF_W'(17'(1 << (DIFF_W - 1)) - 17'(ad));
    assign zprod = ad * comp;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[1])
        begin
            az1_reg  <= zprod[AZ_W-1:0];
            neg1_reg <= d_reg[DIFF_W-1];
        end
    end

    // Stage 3: square of |z|
    always_ff @(posedge clk)
    begin
        if (ctrl.en[2])
        begin
            sq_reg   <= az1_reg * az1_reg;
            az2_reg  <= az1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // Stage 4: |num| = 31*|z|*2^28 + 9*z^2, split at 2^47
    assign t31 = {az2_reg, 5'b0} - T31_W'(az2_reg);
    assign num = {t31, 28'b0} + NUM_W'({sq_reg, 3'b0}) + NUM_W'(sq_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.en[3])
        begin
            h_reg    <= num[NUM_W-1:47];
            low_reg  <= |num[46:0];
            neg3_reg <= neg2_reg;
        end
    end

    // Stage 5: quotient by 5 through the reciprocal
    assign qprod = h_reg * RECIP5;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[4])
        begin
            q_reg    <= qprod[RECIP_SHIFT +: Q_W];
            h5_reg   <= h_reg;
            low5_reg <= low_reg;
            neg5_reg <= neg3_reg;
        end
    end

    // Stage 6: floor toward minus infinity; only a negative inexact value rounds up in magnitude
    assign q5      = {q_reg, 2'b0} + H_W'(q_reg);
    assign inexact = low5_reg || (q5 != h5_reg);
    assign mag     = {1'b0, q_reg} + SINE_W'(neg5_reg && inexact);

    always_ff @(posedge clk)
    begin
        if (ctrl.en[5])
            s_reg <= neg5_reg ? -mag : mag;
    end

    assign sine = s_reg;

endmodule

/* rtl/kcr_merge.sv */
// Merge stage: drift plus signed pair sines per oscillator, saturated and registered.
module kcr_merge
    import kcr_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  drift_t drift,
    input  sine_t  sine [NUM_PAIRS],
    output rate_t  rate [NUM_OSC]
);

    logic signed [SUM_W-1:0] acc [NUM_OSC];
    rate_t                   sat [NUM_OSC];
    rate_t                   rate_reg [NUM_OSC];

    // Per oscillator: minus as first member, plus as second
    always_comb
    begin
        for (int k = 0; k < NUM_OSC; k++)
        begin
            acc[k] = SUM_W'(drift);
            for (int p = 0; p < NUM_PAIRS; p++)
            begin
                if (pair_first(p) == k)
                    acc[k] = acc[k] - SUM_W'(sine[p]);
                if (pair_second(p) == k)
                    acc[k] = acc[k] + SUM_W'(sine[p]);
            end
            if (acc[k] > SAT_HI)
                sat[k] = RATE_W'(SAT_HI);
            else if (acc[k] < SAT_LO)
                sat[k] = RATE_W'(SAT_LO);
            else
                sat[k] = RATE_W'(acc[k]);
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_OSC; k++)
                rate_reg[k] <= sat[k];
        end
    end

    assign rate = rate_reg;

endmodule

/* rtl/kuramoto_coupling_rates_core.sv */
// Top level: phase stream in, coupling rate stream out, one lane per oscillator pair.
//
//  channel   dir  fields (low bit first)                      transfer when
//  s_axis    in   phase_a..phase_f, 16 b each (96 b)          s_tvalid & s_tready
//  m_axis    out  rate_a..rate_f, 16 b each (96 b)            m_tvalid & m_tready
//  cfg       in   base_drift, 15 b                            cfg_we
//
//  One item per cycle sustained while m_tready holds; each item passes six lane stages (difference,
//  two multiplies, wide add, divide-by-5 multiply, sign) and then the merge register.
//  Reset clears all stage valid bits and sets base_drift to 1.0 (4096).
//  A stall on m_tready ripples back only through full stages; empty slots absorb it.
module kuramoto_coupling_rates_core
    import kcr_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [DRIFT_W-1:0]          cfg_wdata,   // base_drift
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [NUM_OSC*ANGLE_BITS-1:0] s_tdata,   // phase_a, phase_b, .. phase_f
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [NUM_OSC*RATE_W-1:0]   m_tdata      // rate_a, rate_b, .. rate_f
);

    localparam int OUT_ST = LANE_STAGES;

    drift_t                 drift_reg;
    logic [OUT_ST:0]        v_reg;
    logic [OUT_ST:0]        v_next;
    logic [OUT_ST:0]        load;
    logic [OUT_ST:0]        in_v;
    logic [OUT_ST:0]        en;
    lane_ctrl_t             lane_ctrl;
    phase_t                 phase [NUM_OSC];
    sine_t                  sine [NUM_PAIRS];
    rate_t                  rate [NUM_OSC];

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drift_reg <= DRIFT_RESET;
        else if (cfg_we)
            drift_reg <= cfg_wdata;
    end

    // Stage valid chain; a stage loads when empty or when its successor loads
    always_comb
    begin
        load[OUT_ST] = !v_reg[OUT_ST] || m_tready;
        for (int k = OUT_ST - 1; k >= 0; k--)
            load[k] = !v_reg[k] || load[k+1];
        in_v   = {v_reg[OUT_ST-1:0], s_tvalid};
        en     = load & in_v;
        v_next = (load & in_v) | (~load & v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign lane_ctrl.en = en[LANE_STAGES-1:0];
    assign s_tready     = load[0];
    assign m_tvalid     = v_reg[OUT_ST];

    // Unpack phases
    always_comb
    begin
        for (int k = 0; k < NUM_OSC; k++)
            phase[k] = s_tdata[k*ANGLE_BITS +: ANGLE_BITS];
    end

    // One lane per pair
    generate
        for (genvar p = 0; p < NUM_PAIRS; p++)
        begin : g_lane
            kcr_lane u_lane (
                .clk     (clk),
                .ctrl    (lane_ctrl),
                .phase_i (phase[pair_first(p)]),
                .phase_j (phase[pair_second(p)]),
                .sine    (sine[p])
            );
        end
    endgenerate

    kcr_merge u_merge (
        .clk   (clk),
        .en    (en[OUT_ST]),
        .drift (drift_reg),
        .sine  (sine),
        .rate  (rate)
    );

    // Pack rates
    always_comb
    begin
        for (int k = 0; k < NUM_OSC; k++)
            m_tdata[k*RATE_W +: RATE_W] = rate[k];
    end

    // Without a pending result every stage can move, so input is open
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register is empty");

    // An accepted item occupies the first stage next cycle
    a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v_reg[0])
        else $error("accepted item lost at first stage");

    // Output drains when nothing waits behind it
    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !v_reg[OUT_ST-1]) |=> !m_tvalid)
        else $error("result repeated after transfer");

    // A full last lane stage moves into the output when the output frees
    a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[OUT_ST-1] && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("finished item not presented");

endmodule

/* test/tb_kuramoto_coupling_rates_core.sv */
// Testbench for kuramoto_coupling_rates_core: streams phase vectors and checks each rate transfer.
module tb_kuramoto_coupling_rates_core
    import kcr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One item: six 16-bit fields, index 0 in the lowest bits
    typedef logic [NUM_OSC-1:0][ANGLE_BITS-1:0] phase_vec_t;
    typedef logic [NUM_OSC-1:0][RATE_W-1:0]     rate_vec_t;

    // Shapes of random phase vectors
    typedef enum int {
        PAT_UNIFORM,
        PAT_CLUSTER,
        PAT_ANTIPHASE,
        PAT_LATTICE
    } phase_pattern_t;

    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES = 300;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [DRIFT_W-1:0]        cfg_wdata;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [NUM_OSC*ANGLE_BITS-1:0] s_tdata;    // phase_a, phase_b, .. phase_f
    logic                      m_tvalid;
    logic                      m_tready;
    logic [NUM_OSC*RATE_W-1:0] m_tdata;    // rate_a, rate_b, .. rate_f

    // Expected rate vectors, oldest first
    rate_vec_t expected_rates[$];
    rate_vec_t want_rates;
    rate_vec_t got_rates;

    drift_t drift_now;
    bit     src_calm;
    bit     sink_calm;
    int     sink_hold;
    int     items_sent;
    int     rates_checked;
    int     drift_writes;
    int     mismatches;
    int     unexpected;
    int     input_stalls;

    kuramoto_coupling_rates_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Parabolic sine of d*pi/32768 in Q1.12, exact then floored
    function automatic int pair_sine(input logic signed [DIFF_W-1:0] d);
        longint dl;
        longint ad;
        longint z;
        longint az;
        longint num;
        longint den;
        dl  = d;
        ad  = (dl < 0) ? -dl : dl;
        z   = dl * (64'sd32768 - ad);
        az  = (z < 0) ? -z : z;
        num = 64'sd31 * z * 64'sd268435456 + 64'sd9 * z * az;
        den = 64'sd5 * (64'sd1 <<< 47);
        if (num >= 0)
            return int'(num / den);
        return -int'((-num + den - 1) / den);
    endfunction

    // All-to-all coupling: rate i loses s(i,j), rate j gains it; saturate once
    function automatic rate_vec_t coupling_rates(input phase_vec_t ph, input drift_t drift);
        int               acc[NUM_OSC];
        int               s;
        logic [DIFF_W-1:0] d;
        rate_vec_t        r;
        for (int i = 0; i < NUM_OSC; i++)
            acc[i] = int'(drift);
        for (int i = 0; i < NUM_OSC; i++)
        begin
            for (int j = i + 1; j < NUM_OSC; j++)
            begin
                d = ph[i] - ph[j];
                s = pair_sine(signed'(d));
                acc[i] -= s;
                acc[j] += s;
            end
        end
        for (int i = 0; i < NUM_OSC; i++)
        begin
            if (acc[i] > 32767)
                acc[i] = 32767;
            if (acc[i] < -32768)
                acc[i] = -32768;
            r[i] = acc[i][RATE_W-1:0];
        end
        return r;
    endfunction

    // Oscillator 0 at one angle, the rest at another
    function automatic phase_vec_t lead_phase(input logic [15:0] lead, input logic [15:0] rest);
        phase_vec_t ph;
        for (int k = 0; k < NUM_OSC; k++)
            ph[k] = rest;
        ph[0] = lead;
        return ph;
    endfunction

    // Random vector: half uniform, the rest uniform, clustered, antiphase or near lattice angles
    function automatic phase_vec_t random_phases();
        phase_vec_t     ph;
        phase_pattern_t pat;
        logic [15:0]    base;
        if ($urandom_range(99) < 50)
            pat = PAT_UNIFORM;
        else
            pat = phase_pattern_t'($urandom_range(3));
        base = 16'($urandom);
        for (int k = 0; k < NUM_OSC; k++)
        begin
            case (pat)
                PAT_UNIFORM:   ph[k] = 16'($urandom);
                PAT_CLUSTER:   ph[k] = base + 16'($urandom_range(512)) - 16'd256;
                PAT_ANTIPHASE: ph[k] = base + ((k % 2) ? 16'h8000 : 16'h0000)
                                       + 16'($urandom_range(16)) - 16'd8;
                default:       ph[k] = 16'($urandom_range(7)) * 16'h2000
                                       + 16'($urandom_range(2)) - 16'd1;
            endcase
        end
        return ph;
    endfunction

    function automatic drift_t random_drift();
        return drift_t'($urandom_range(16384) - 8192);
    endfunction

    // Offer one phase vector, with random idle cycles, until it transfers
    task automatic send_phases(input phase_vec_t ph);
        while (!src_calm && $urandom_range(99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ph;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_rates.push_back(coupling_rates(ph, drift_now));
        items_sent++;
    endtask

    // Wait for all rates to come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_rates.size() != 0)
            @(posedge clk);
    endtask

    // Change base_drift only with the pipeline empty
    task automatic write_drift(input drift_t value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        drift_now = value;
        drift_writes++;
    endtask

    // Reset value of base_drift
    task automatic test_reset_drift();
        send_phases('0);
        send_phases(lead_phase(16'd12345, 16'd12345));
    endtask

    // Quarter turns, exactly pi, a step either side of 0 and pi, equal phases, spread vectors
    task automatic test_directed_angles();
        phase_vec_t ph;
        send_phases(lead_phase(16'h4000, 16'h0000));
        send_phases(lead_phase(16'hC000, 16'h0000));
        send_phases(lead_phase(16'h8000, 16'h0000));
        send_phases(lead_phase(16'h0001, 16'h0000));
        send_phases(lead_phase(16'hFFFF, 16'h0000));
        send_phases(lead_phase(16'h7FFF, 16'h0000));
        send_phases(lead_phase(16'h8001, 16'h0000));
        send_phases(lead_phase(16'h7FFF, 16'h7FFF));
        send_phases(lead_phase(16'h8000, 16'h8000));
        for (int k = 0; k < NUM_OSC; k++)
            ph[k] = (k % 2) ? 16'h8000 : 16'h0000;
        send_phases(ph);
        for (int k = 0; k < NUM_OSC; k++)
            ph[k] = 16'(k * 16384);
        send_phases(ph);
        for (int k = 0; k < NUM_OSC; k++)
            ph[k] = 16'(k * 10923);
        send_phases(ph);
    endtask

    // Largest coupling sums at both drift extremes, then drift 0 and -1
    task automatic test_drift_extremes();
        write_drift(drift_t'(8192));
        send_phases(lead_phase(16'h0000, 16'h4000));
        send_phases(lead_phase(16'h0000, 16'hC000));
        write_drift(drift_t'(-8192));
        send_phases(lead_phase(16'h0000, 16'h4000));
        send_phases(lead_phase(16'h0000, 16'hC000));
        write_drift(drift_t'(0));
        send_phases(lead_phase(16'h2000, 16'hE000));
        write_drift(drift_t'(-1));
        send_phases(lead_phase(16'h8000, 16'h0000));
    endtask

    // Random vectors over several drift settings
    task automatic test_random_drifts();
        for (int round = 0; round < 10; round++)
        begin
            if (round == 0)
                write_drift(drift_t'(8192));
            else if (round == 1)
                write_drift(drift_t'(-8192));
            else
                write_drift(random_drift());
            for (int n = 0; n < 150; n++)
                send_phases(random_phases());
        end
    endtask

    // Long stretch with neither side idling
    task automatic test_back_to_back();
        write_drift(random_drift());
        src_calm  = 1'b1;
        sink_calm = 1'b1;
        for (int n = 0; n < 150; n++)
            send_phases(random_phases());
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_hold();
        drain_results();
        src_calm  = 1'b1;
        sink_hold = HOLD_CYCLES;
        for (int n = 0; n < 60; n++)
            send_phases(random_phases());
        src_calm  = 1'b0;
    endtask

    // Receiver: random ready, or a counted hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                m_tready <= 1'b0;
                sink_hold--;
            end
            else
                m_tready <= sink_calm || ($urandom_range(99) >= 13);
        end
    end

    // Count cycles where the block refuses an offered item
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && !s_tready)
            input_stalls++;
    end

    // Compare each rate transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_rates.size() == 0)
            begin
                if (mismatches + unexpected < MAX_REPORTS)
                    $display("unexpected rate transfer %h", m_tdata);
                unexpected++;
            end
            else
            begin
                want_rates = expected_rates.pop_front();
                got_rates  = m_tdata;
                for (int k = 0; k < NUM_OSC; k++)
                begin
                    if (got_rates[k] !== want_rates[k])
                    begin
                        if (mismatches + unexpected < MAX_REPORTS)
                            $display("rate %0d mismatch: expected %0d got %0d", k,
                                     $signed(want_rates[k]), $signed(got_rates[k]));
                        mismatches++;
                    end
                end
                rates_checked += NUM_OSC;
            end
        end
    end

    // Hard stop
    initial
    begin
        #2000000;
        $display("FAIL kuramoto_coupling_rates_core");
        $finish;
    end

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        src_calm  = 1'b0;
        sink_calm = 1'b0;
        sink_hold = 0;
        drift_now = DRIFT_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_drift();
        test_directed_angles();
        test_drift_extremes();
        test_random_drifts();
        test_back_to_back();
        test_output_hold();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d phase vectors over %0d drift settings, %0d rates compared",
                 items_sent, drift_writes, rates_checked);
        $display("input refused for %0d cycles under output back-pressure", input_stalls);
        if (mismatches == 0 && unexpected == 0 && expected_rates.size() == 0)
            $display("PASS kuramoto_coupling_rates_core");
        else
            $display("FAIL kuramoto_coupling_rates_core");
        $finish;
    end

endmodule
